@@ design/stsl_pkg.sv @@
// ----------------------------------------------------------------------------
// stsl_pkg
// Shared types and constants for the speed-scheduled torque slew limiter.
// ----------------------------------------------------------------------------
package stsl_pkg;

  localparam int unsigned FULL_SCALE      = 1000;
  localparam int unsigned MAX_STEP_MS_DEF = 50;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned TRQ_W   = 10;
  localparam int unsigned SPD_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RAMP_W  = 16;
  localparam int unsigned THR_W   = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_ENABLE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STANDSTILL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_RAMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MOVING_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_SPEED    = 3'd4;

  // register reset values
  localparam logic              RST_RAMP_ENABLE  = 1'b1;
  localparam logic [RAMP_W-1:0] RST_STANDSTILL   = 16'd500;
  localparam logic [RAMP_W-1:0] RST_MOVING_RAMP  = 16'd200;
  localparam logic [THR_W-1:0]  RST_MOVING_SPEED = 15'd320;
  localparam logic [THR_W-1:0]  RST_OFF_SPEED    = 15'd1280;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture transaction, dt, coarse ramp choice
    logic mul1;       // standstill * moving_speed
    logic mul2;       // (moving - standstill) * speed
    logic div_num;    // start interpolation divide
    logic take_ramp;  // latch interpolated ramp time
    logic div_step;   // start step divide
    logic finish;     // update accumulator, load output register
  } stsl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic interp;       // ramp enabled, speed below off_speed and strictly between zero and moving_speed
    logic div_busy;
    logic step_needed;  // rising request with non-zero ramp
    logic out_free;     // output register can take a result
  } stsl_status_t;

endpackage

@@ design/stsl_div.sv @@
// ----------------------------------------------------------------------------
// stsl_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stsl_div
  import stsl_pkg::*;
#(
  parameter int unsigned DIVW = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVW-1:0]   dividend,
  input  logic [RAMP_W-1:0] divisor,
  output logic              busy,
  output logic [DIVW-1:0]   quotient
);

  localparam int unsigned CNT_W = (DIVW > 1) ? $clog2(DIVW) : 1;

  logic              busy_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVW-1:0]   quo_r;
  logic [RAMP_W-1:0] rem_r;
  logic [RAMP_W-1:0] den_r;
  logic [RAMP_W:0]   shifted;
  logic [RAMP_W:0]   trial;
  logic              bit_q;

  assign shifted = {rem_r, quo_r[DIVW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign bit_q   = (shifted >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(DIVW - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      den_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVW-2:0], bit_q};
      rem_r <= bit_q ? trial[RAMP_W-1:0] : shifted[RAMP_W-1:0];
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

@@ design/stsl_ctrl.sv @@
// ----------------------------------------------------------------------------
// stsl_ctrl
// Sequencer: interpolation multiplies, two divides, result handoff.
// ----------------------------------------------------------------------------
module stsl_ctrl
  import stsl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  stsl_status_t status,
  output stsl_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL1  = 8'b0000_0010,
    S_MUL2  = 8'b0000_0100,
    S_NDIV  = 8'b0000_1000,
    S_NWAIT = 8'b0001_0000,
    S_STEP  = 8'b0010_0000,
    S_SWAIT = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_MUL1;
        end
      end
      S_MUL1: begin
        // coarse choice already made at load when not interpolating
        if (status.interp) begin
          cmd.mul1  = 1'b1;
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = S_NDIV;
      end
      S_NDIV: begin
        cmd.div_num = 1'b1;
        state_nxt   = S_NWAIT;
      end
      S_NWAIT: begin
        if (!status.div_busy) begin
          cmd.take_ramp = 1'b1;
          state_nxt     = S_STEP;
        end
      end
      S_STEP: begin
        if (status.step_needed) begin
          cmd.div_step = 1'b1;
          state_nxt    = S_SWAIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SWAIT: begin
        if (!status.div_busy) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

@@ design/stsl_dp.sv @@
// ----------------------------------------------------------------------------
// stsl_dp
// Datapath: config registers, dt, ramp choice, accumulator, output register.
// ----------------------------------------------------------------------------
module stsl_dp
  import stsl_pkg::*;
#(
  parameter int unsigned MAX_STEP_MS = MAX_STEP_MS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic [TRQ_W-1:0]     in_torque_request,
  input  logic signed [SPD_W-1:0] in_vehicle_speed,
  input  logic [TIME_W-1:0]    in_time_now_ms,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TRQ_W-1:0]     out_torque_out,
  output logic [RAMP_W-1:0]    out_ramp_time_used,
  output logic                 out_ramp_limiting,
  input  stsl_cmd_t            cmd,
  output stsl_status_t         status
);

  localparam int unsigned DT_W    = $clog2(MAX_STEP_MS + 1);
  localparam int unsigned STEPN_W = $clog2(FULL_SCALE * MAX_STEP_MS + 1);
  localparam int unsigned NUMER_W = STEPN_W + FRAC_BITS;
  localparam int unsigned DIVW    = (NUMER_W > 32) ? NUMER_W : 32;
  localparam int unsigned ACCW    = TRQ_W + FRAC_BITS;
  localparam int unsigned SUMW    = ((DIVW > ACCW) ? DIVW : ACCW) + 1;

  // config registers
  logic              ramp_enable_r;
  logic [RAMP_W-1:0] standstill_r;
  logic [RAMP_W-1:0] moving_ramp_r;
  logic [THR_W-1:0]  moving_speed_r;
  logic [THR_W-1:0]  off_speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_enable_r  <= RST_RAMP_ENABLE;
      standstill_r   <= RST_STANDSTILL;
      moving_ramp_r  <= RST_MOVING_RAMP;
      moving_speed_r <= RST_MOVING_SPEED;
      off_speed_r    <= RST_OFF_SPEED;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RAMP_ENABLE:  ramp_enable_r  <= cfg_data[0];
        REG_STANDSTILL:   standstill_r   <= cfg_data;
        REG_MOVING_RAMP:  moving_ramp_r  <= cfg_data;
        REG_MOVING_SPEED: moving_speed_r <= cfg_data[THR_W-1:0];
        REG_OFF_SPEED:    off_speed_r    <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  logic              first_r;
  logic [TIME_W-1:0] last_time_r;
  logic [ACCW-1:0]   accum_r;
  logic              out_valid_r;

  // per-transaction payload
  logic [TRQ_W-1:0]  req_r;
  logic [THR_W-1:0]  speed_r;
  logic [DT_W-1:0]   dt_r;
  logic              interp_r;
  logic [RAMP_W-1:0] ramp_r;
  logic [30:0]       pa_r;
  logic signed [32:0] pb_r;
  logic              neg_r;

  logic [TRQ_W-1:0]  req_sat;
  logic [TIME_W-1:0] dt_raw;
  logic [DT_W-1:0]   dt_clamp;
  logic signed [SPD_W:0] spd_x;
  logic              ge_off, ge_mov, le_zero;
  logic [RAMP_W-1:0] ramp_coarse;

  assign req_sat  = (in_torque_request > TRQ_W'(FULL_SCALE)) ? TRQ_W'(FULL_SCALE)
                                                             : in_torque_request;
  assign dt_raw   = first_r ? '0 : (in_time_now_ms - last_time_r);
  assign dt_clamp = (dt_raw > TIME_W'(MAX_STEP_MS)) ? DT_W'(MAX_STEP_MS)
                                                    : dt_raw[DT_W-1:0];
  assign spd_x    = {in_vehicle_speed[SPD_W-1], in_vehicle_speed};
  assign ge_off   = spd_x >= $signed({2'b00, off_speed_r});
  assign ge_mov   = spd_x >= $signed({2'b00, moving_speed_r});
  assign le_zero  = spd_x <= $signed(17'sd0);

  always_comb begin
    if (!ramp_enable_r || ge_off) begin
      ramp_coarse = '0;
    end else if (ge_mov) begin
      ramp_coarse = moving_ramp_r;
    end else if (le_zero) begin
      ramp_coarse = standstill_r;
    end else begin
      ramp_coarse = '0;  // replaced by the interpolated value
    end
  end

  // interpolation products and sum
  logic signed [RAMP_W:0] ramp_diff;
  logic signed [33:0]     num_s;
  assign ramp_diff = $signed({1'b0, moving_ramp_r}) - $signed({1'b0, standstill_r});
  assign num_s     = $signed({3'b000, pa_r}) + {pb_r[32], pb_r};

  // shared divider
  logic              div_start;
  logic [DIVW-1:0]   div_dividend;
  logic [RAMP_W-1:0] div_divisor;
  logic              div_busy;
  logic [DIVW-1:0]   div_quo;
  logic [STEPN_W-1:0] step_prod;

  assign step_prod    = STEPN_W'(FULL_SCALE) * STEPN_W'(dt_r);
  assign div_start    = cmd.div_num | cmd.div_step;
  assign div_dividend = cmd.div_num ? DIVW'(num_s[31:0])
                                    : DIVW'({step_prod, {FRAC_BITS{1'b0}}});
  assign div_divisor  = cmd.div_num ? {1'b0, moving_speed_r} : ramp_r;

  stsl_div #(.DIVW(DIVW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // accumulator update
  logic [ACCW-1:0] target;
  logic [SUMW-1:0] sum;
  logic [ACCW-1:0] accum_nxt;
  logic            step_needed;

  assign target      = {req_r, {FRAC_BITS{1'b0}}};
  assign step_needed = (ramp_r != '0) && (target > accum_r);
  assign sum         = SUMW'(accum_r) + SUMW'(div_quo);
  assign accum_nxt   = (step_needed && (sum < SUMW'(target))) ? sum[ACCW-1:0] : target;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      last_time_r <= '0;
      accum_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        first_r     <= 1'b0;
        last_time_r <= in_time_now_ms;
      end
      if (cmd.finish) begin
        accum_r     <= accum_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= req_sat;
      speed_r  <= in_vehicle_speed[THR_W-1:0];
      dt_r     <= dt_clamp;
      ramp_r   <= ramp_coarse;
      interp_r <= ramp_enable_r && !ge_off && !ge_mov && !le_zero;
    end
    if (cmd.mul1) begin
      pa_r <= standstill_r * moving_speed_r;
    end
    if (cmd.mul2) begin
      pb_r <= ramp_diff * $signed({1'b0, speed_r});
    end
    if (cmd.div_num) begin
      neg_r <= num_s[33];
    end
    if (cmd.take_ramp) begin
      ramp_r <= neg_r ? '0 : div_quo[RAMP_W-1:0];
    end
    if (cmd.finish) begin
      out_torque_out     <= accum_nxt[ACCW-1 -: TRQ_W];
      out_ramp_time_used <= ramp_r;
      out_ramp_limiting  <= (accum_nxt < target);
    end
  end

  assign out_valid          = out_valid_r;
  assign status.interp      = interp_r;
  assign status.div_busy    = div_busy;
  assign status.step_needed = step_needed;
  assign status.out_free    = !out_valid_r || out_ready;

endmodule

@@ design/speed_scheduled_torque_slew_limiter.sv @@
// ----------------------------------------------------------------------------
// speed_scheduled_torque_slew_limiter
// Rising-edge torque slew limiter with a speed-scheduled ramp time.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in_     | input     | in_valid/in_ready  | torque_request, vehicle_speed,
//          |           |                    | time_now_ms
//  out_    | output    | out_valid/out_ready| torque_out, ramp_time_used,
//          |           |                    | ramp_limiting
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
//  One transaction at a time. A request under a register ramp time that is
//  followed at once (falling, equal or zero ramp) skips the divider; a rising
//  one uses it once for the accumulator step. An interpolated ramp time takes
//  one more divide before that. The shared divider (DIVW = 32 at default
//  settings) yields one quotient bit per cycle; in_ready returns in the same
//  cycle as out_valid, when the result is loaded.
//  Reset (rst_n low, synchronous) restores register defaults, clears the
//  accumulator and marks the next transaction as first (dt = 0).
//  A result waits in the output register; the next transaction is accepted
//  meanwhile and only stalls at its own handoff while out_ready stays low.
//
module speed_scheduled_torque_slew_limiter
  import stsl_pkg::*;
#(
  parameter int unsigned MAX_STEP_MS = MAX_STEP_MS_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DAT_W-1:0]    cfg_data,
  // request channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [TRQ_W-1:0]        in_torque_request,
  input  logic signed [SPD_W-1:0] in_vehicle_speed,
  input  logic [TIME_W-1:0]       in_time_now_ms,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TRQ_W-1:0]        out_torque_out,
  output logic [RAMP_W-1:0]       out_ramp_time_used,
  output logic                    out_ramp_limiting
);

  stsl_cmd_t    cmd;
  stsl_status_t status;

  // sequencer: owns in_ready, steps the datapath
  stsl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: registers, ramp choice, divider, accumulator, output stage
  stsl_dp #(
    .MAX_STEP_MS (MAX_STEP_MS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_torque_request  (in_torque_request),
    .in_vehicle_speed   (in_vehicle_speed),
    .in_time_now_ms     (in_time_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_torque_out     (out_torque_out),
    .out_ramp_time_used (out_ramp_time_used),
    .out_ramp_limiting  (out_ramp_limiting),
    .cmd                (cmd),
    .status             (status)
  );

  // one transaction in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while previous transaction in flight");

  // accumulator never exceeds full scale
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_torque_out <= TRQ_W'(FULL_SCALE))
    else $error("torque_out above full scale");

  // limiting only happens with an active ramp
  a_limit_needs_ramp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ramp_limiting |-> out_ramp_time_used != '0)
    else $error("ramp_limiting set with zero ramp time");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speed-scheduled torque slew limiter. A shadow
// model of the ramp tracks every accepted update, predicts torque, ramp time
// and the limiting flag, and compares them with each result in order.
// Stimulus is a directed opening followed by ramp episodes and noise under
// several register settings, with random back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import stsl_pkg::*;

  localparam int IDLE_PCT        = 22;    // idle share per side, percent
  localparam int HOLD_OFF_CYCLES = 600;   // long receiver stall
  localparam int WATCHDOG_LIMIT  = 5000;  // cycles with no transaction at all
  localparam int DRAIN_CYCLES    = 100;   // above the interpolated-path latency

  // indexes past the register list, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_OFF_SPEED + 3'd1;

  typedef struct {
    logic [TRQ_W-1:0]  torque;
    logic [RAMP_W-1:0] ramp_ms;
    logic              limiting;
  } torque_result_t;

  // Shadow of the limiter: registers, ramp state and the results still due.
  class torque_ramp_shadow;
    int               ramp_en;
    int               standstill_ms;
    int               moving_ms;
    int               moving_spd;
    int               off_spd;
    logic [TIME_W-1:0] last_ms;
    bit               no_history;
    longint unsigned  accum;          // torque in Q10.FRAC_BITS
    torque_result_t   torque_due[$];
    int               n_checked;
    int               n_errors;
    int               n_limited;
    int               n_interp;
    int               n_bypass;

    function new();
      ramp_en       = RST_RAMP_ENABLE;
      standstill_ms = RST_STANDSTILL;
      moving_ms     = RST_MOVING_RAMP;
      moving_spd    = RST_MOVING_SPEED;
      off_spd       = RST_OFF_SPEED;
      last_ms       = '0;
      no_history    = 1'b1;
      accum         = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
      case (idx)
        REG_RAMP_ENABLE:  ramp_en       = data[0];
        REG_STANDSTILL:   standstill_ms = data;
        REG_MOVING_RAMP:  moving_ms     = data;
        REG_MOVING_SPEED: moving_spd    = data[THR_W-1:0];
        REG_OFF_SPEED:    off_spd       = data[THR_W-1:0];
        default: ;
      endcase
    endfunction

    // off test first, then moving, then standstill, interpolation last
    function int unsigned ramp_for_speed(int spd);
      longint num;
      if (ramp_en == 0) return 0;
      if (spd >= off_spd) return 0;
      if (spd >= moving_spd) return moving_ms;
      if (spd <= 0) return standstill_ms;
      n_interp++;
      num = longint'(standstill_ms) * moving_spd
          + (longint'(moving_ms) - standstill_ms) * spd;
      if (num < 0) return 0;
      return 32'((num / moving_spd) & 'hFFFF);
    endfunction

    function void note_update(logic [TRQ_W-1:0] req, logic signed [SPD_W-1:0] spd,
                              logic [TIME_W-1:0] now);
      torque_result_t  r;
      int unsigned     req_sat;
      logic [TIME_W-1:0] dt;
      int unsigned     ramp;
      longint unsigned target;
      longint unsigned step;
      int              s;
      req_sat = (req > FULL_SCALE) ? FULL_SCALE : req;
      dt = no_history ? '0 : now - last_ms;
      if (dt > MAX_STEP_MS_DEF) dt = MAX_STEP_MS_DEF;
      last_ms    = now;
      no_history = 1'b0;
      s      = spd;
      ramp   = ramp_for_speed(s);
      target = longint'(req_sat) << FRAC_BITS_DEF;
      if (ramp == 0 || target <= accum) begin
        accum = target;
      end else begin
        step  = ((64'(FULL_SCALE) * dt) << FRAC_BITS_DEF) / ramp;
        accum = accum + step;
        if (accum > target) accum = target;
      end
      r.torque   = TRQ_W'(accum >> FRAC_BITS_DEF);
      r.ramp_ms  = RAMP_W'(ramp);
      r.limiting = (accum < target);
      if (ramp == 0) n_bypass++;
      if (r.limiting) n_limited++;
      torque_due.push_back(r);
    endfunction

    function void check_result(logic [TRQ_W-1:0] trq, logic [RAMP_W-1:0] ramp, logic lim);
      torque_result_t e;
      if (torque_due.size() == 0) begin
        $error("unexpected result: torque_out=%0d ramp_time_used=%0d ramp_limiting=%0b",
               trq, ramp, lim);
        n_errors++;
        return;
      end
      e = torque_due.pop_front();
      n_checked++;
      if (trq !== e.torque) begin
        $error("torque_out: expected %0d, actual %0d", e.torque, trq);
        n_errors++;
      end
      if (ramp !== e.ramp_ms) begin
        $error("ramp_time_used: expected %0d, actual %0d", e.ramp_ms, ramp);
        n_errors++;
      end
      if (lim !== e.limiting) begin
        $error("ramp_limiting: expected %0b, actual %0b", e.limiting, lim);
        n_errors++;
      end
    endfunction

    function int pending();
      return torque_due.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                    clk;
  logic                    rst_n = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [CFG_DAT_W-1:0]    cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [TRQ_W-1:0]        in_torque_request = '0;
  logic signed [SPD_W-1:0] in_vehicle_speed = '0;
  logic [TIME_W-1:0]       in_time_now_ms = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [TRQ_W-1:0]        out_torque_out;
  logic [RAMP_W-1:0]       out_ramp_time_used;
  logic                    out_ramp_limiting;

  torque_ramp_shadow shadow;
  bit                quiet_mode = 1'b0;  // no idling on either side
  int                hold_requests = 0;  // bumped to ask for a long receiver stall
  int                stall_cycles = 0;
  int                n_sent = 0;
  int                n_settings = 0;
  logic [TIME_W-1:0] clock_ms = 32'hFFFF_FFF0;  // starts just short of the wrap

  speed_scheduled_torque_slew_limiter uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_torque_request  (in_torque_request),
    .in_vehicle_speed   (in_vehicle_speed),
    .in_time_now_ms     (in_time_now_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_torque_out     (out_torque_out),
    .out_ramp_time_used (out_ramp_time_used),
    .out_ramp_limiting  (out_ramp_limiting)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels are sampled at the edge, before any driver update.
  // The result is checked first so it never meets the update taken this edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        shadow.check_result(out_torque_out, out_ramp_time_used, out_ramp_limiting);
      if (in_valid && in_ready)
        shadow.note_update(in_torque_request, in_vehicle_speed, in_time_now_ms);
    end
  end

  // Receiver: random stalls, none in quiet mode, and a long hold-off on request.
  // It owns its own counter so the sender never writes it.
  initial begin
    int hold_left;
    int served;
    hold_left = 0;
    served    = 0;
    forever begin
      @(posedge clk);
      if (served != hold_requests) begin
        served    = hold_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_mode || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Watchdog: any transaction on either channel clears the count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("speed_scheduled_torque_slew_limiter verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // Offer one update; the timestamp moves on by elapsed ms (wraps mod 2^32).
  task automatic send_update(input logic [TRQ_W-1:0] req, input logic [SPD_W-1:0] spd,
                             input logic [TIME_W-1:0] elapsed);
    if (!quiet_mode && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk);
    end
    clock_ms = clock_ms + elapsed;
    in_valid          <= 1'b1;
    in_torque_request <= req;
    in_vehicle_speed  <= spd;
    in_time_now_ms    <= clock_ms;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Sender stops offering until every predicted result has come back.
  // It first waits on the clock, so an update taken at the last edge is already noted.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it after its last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    shadow.set_reg(idx, data);
  endtask

  task automatic program_regs(input logic [CFG_DAT_W-1:0] en, input logic [CFG_DAT_W-1:0] ss,
                              input logic [CFG_DAT_W-1:0] mr, input logic [CFG_DAT_W-1:0] ms,
                              input logic [CFG_DAT_W-1:0] off);
    wait_drained();
    write_reg(REG_RAMP_ENABLE, en);
    write_reg(REG_STANDSTILL, ss);
    write_reg(REG_MOVING_RAMP, mr);
    write_reg(REG_MOVING_SPEED, ms);
    write_reg(REG_OFF_SPEED, off);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Speeds biased toward the current thresholds, with full-range noise.
  function automatic logic [SPD_W-1:0] pick_speed();
    int ms;
    int off;
    ms  = shadow.moving_spd;
    off = shadow.off_spd;
    case ($urandom_range(9))
      0:       return SPD_W'($urandom);
      1:       return SPD_W'(-int'($urandom_range(1, 200)));
      2:       return '0;
      3, 4: begin
        if (ms > 1) return SPD_W'($urandom_range(1, ms - 1));
        else return SPD_W'($urandom_range(0, 5));
      end
      5:       return SPD_W'(ms + int'($urandom_range(0, 40)));
      6:       return SPD_W'(off + int'($urandom_range(0, 2)) - 1);
      7:       return SPD_W'(ms + int'($urandom_range(0, 2)) - 1);
      default: return SPD_W'($urandom_range(0, off + 100));
    endcase
  endfunction

  // Elapsed time: mostly inside the clamp, some at/over it, some wild jumps.
  function automatic logic [TIME_W-1:0] pick_elapsed();
    case ($urandom_range(19))
      0:                  return '0;
      1:                  return MAX_STEP_MS_DEF;
      2:                  return MAX_STEP_MS_DEF + 1;
      3:                  return $urandom;  // includes going backwards
      4:                  return $urandom_range(MAX_STEP_MS_DEF + 2, 100000);
      5, 6, 7, 8, 9, 10:  return $urandom_range(1, 10);
      default:            return $urandom_range(1, MAX_STEP_MS_DEF - 1);
    endcase
  endfunction

  // Mostly ramp episodes (a held rising request, then a drop), some noise.
  task automatic run_traffic(input int n_items);
    int                sent;
    int                len;
    logic [TRQ_W-1:0]  goal;
    logic [SPD_W-1:0]  spd;
    logic [TIME_W-1:0] dt;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        goal = TRQ_W'($urandom_range(1, 1023));
        spd  = pick_speed();
        len  = $urandom_range(2, 20);
        repeat (len) begin
          if ($urandom_range(3) == 0) spd = pick_speed();
          dt = ($urandom_range(4) == 0) ? pick_elapsed() : $urandom_range(1, 30);
          send_update(goal, spd, dt);
          sent++;
        end
        send_update(TRQ_W'($urandom_range(0, goal)), pick_speed(), pick_elapsed());
        sent++;
      end else begin
        send_update(TRQ_W'($urandom_range(0, 1023)), pick_speed(), pick_elapsed());
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    shadow = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    n_settings = 1;

    // Directed, reset defaults (500/200 ms, 320/1280 speed).
    send_update(10'd1000, 16'sd0, 0);       // first update: no elapsed time
    send_update(10'd1000, 16'sd0, 10);      // standstill ramp
    send_update(10'd1023, 16'sd160, 10);    // timestamp wraps, request saturates, interpolated
    send_update(10'd1000, 16'sd320, 50);    // exactly the moving speed, full clamp step
    send_update(10'd1000, 16'sd319, 100);   // elapsed clamped
    send_update(10'd1000, 16'sd1, 0);       // zero elapsed, lowest interpolated speed
    send_update(10'd0, 16'sd1279, 5);       // falling request follows at once
    send_update(10'd1000, 16'sd1280, 5);    // off speed: pass-through
    send_update(10'd1000, 16'sd0, 5);       // equal request
    send_update(10'd500, -16'sd32768, 1);   // most negative speed, falling
    send_update(10'd600, 16'sd32767, 1);    // top speed: pass-through
    send_update(10'd601, -16'sd1, 1);       // step overshoots, capped at the request
    send_update(10'd1000, 16'sd0, 32'hFFFF_FFFF);  // timestamp steps back one
    send_update(10'd682, 16'sh5555, 3);
    send_update(10'd341, 16'shAAAA, 3);

    // Register writes are masked to width; spare indexes are dropped.
    wait_drained();
    write_reg(REG_RAMP_ENABLE, 16'hFFFE);   // enable bit reads as 0
    write_reg(REG_MOVING_SPEED, 16'h8010);  // top bit drops: 16
    for (i = REG_SPARE_FIRST; i < 2**CFG_IDX_W; i++)
      write_reg(CFG_IDX_W'(i), CFG_DAT_W'($urandom));
    cfg_we <= 1'b0;
    n_settings++;
    send_update(10'd900, 16'sd8, 7);
    send_update(10'd0, 16'sd8, 7);
    wait_drained();
    write_reg(REG_RAMP_ENABLE, 16'h0001);
    cfg_we <= 1'b0;
    send_update(10'd900, 16'sd8, 7);        // interpolates against moving speed 16
    send_update(10'd900, 16'sd8, 20);

    // Extremes and corner settings.
    program_regs(1, 16'hFFFF, 1, 16'h7FFF, 16'h7FFF);
    run_traffic(150);
    program_regs(1, 1, 16'hFFFF, 2, 3);
    run_traffic(120);
    program_regs(0, CFG_DAT_W'($urandom), CFG_DAT_W'($urandom),
                 CFG_DAT_W'($urandom_range(1, 2000)), CFG_DAT_W'($urandom_range(2001, 4000)));
    run_traffic(80);
    program_regs(1, 300, 100, 0, 1000);     // zero moving speed: no interpolation
    run_traffic(120);
    program_regs(1, 400, 150, 1000, 500);   // thresholds out of order
    run_traffic(120);
    program_regs(1, 0, 0, 320, 1280);       // zero ramp registers: pass-through
    run_traffic(100);
    program_regs(1, 0, 900, 200, 800);      // interpolation up from a zero ramp
    run_traffic(100);

    // Defaults again, flat out with no idling on either side.
    program_regs(CFG_DAT_W'(RST_RAMP_ENABLE), CFG_DAT_W'(RST_STANDSTILL),
                 CFG_DAT_W'(RST_MOVING_RAMP), CFG_DAT_W'(RST_MOVING_SPEED),
                 CFG_DAT_W'(RST_OFF_SPEED));
    quiet_mode = 1'b1;
    run_traffic(250);
    quiet_mode = 1'b0;

    // Receiver holds off while updates keep coming; input must back up.
    hold_requests++;
    run_traffic(100);
    // Sender pauses until everything is back, then carries on.
    wait_drained();
    run_traffic(60);

    // Random settings, mostly sane thresholds.
    repeat (5) begin
      i = $urandom_range(1, 2000);
      program_regs(CFG_DAT_W'($urandom_range(9) != 0),
                   ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom)
                                            : CFG_DAT_W'($urandom_range(1, 2000)),
                   ($urandom_range(3) == 0) ? CFG_DAT_W'($urandom)
                                            : CFG_DAT_W'($urandom_range(1, 2000)),
                   CFG_DAT_W'(i), CFG_DAT_W'(i + int'($urandom_range(1, 2000))));
      run_traffic(130);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d updates (%0d results checked) under %0d register settings",
             n_sent, shadow.n_checked, n_settings);
    $display("ramp-limited %0d, interpolated ramp %0d, pass-through %0d",
             shadow.n_limited, shadow.n_interp, shadow.n_bypass);
    if (shadow.n_errors == 0 && shadow.pending() == 0)
      $display("speed_scheduled_torque_slew_limiter verification clean");
    else
      $display("speed_scheduled_torque_slew_limiter verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/stsl_pkg.sv
design/stsl_div.sv
design/stsl_ctrl.sv
design/stsl_dp.sv
design/speed_scheduled_torque_slew_limiter.sv
sim/tb_top.sv
